/* rtl/core/mp2d_pkg.sv */
// Shared constants, register indexes and control/status types of the max pooling block.
`default_nettype none
package mp2d_pkg;

    // Image store geometry.
    localparam int MAX_HEIGHT   = 32;
    localparam int MAX_WIDTH    = 32;
    localparam int MAX_CHANNELS = 8;
    localparam int MAX_KERNEL   = 7;
    localparam int SAMPLE_W     = 16;
    localparam int STORE_DEPTH  = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);

    // Most negative sample value, the starting point of every window scan.
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // Field widths of the input and result words.
    localparam int ROW_W   = 5;
    localparam int COL_W   = 5;
    localparam int CHAN_W  = 3;
    localparam int INDEX_W = 6;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 6;

    localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAD      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNELS = 3'd5;

    // Operation codes carried in the func field.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // capture the accepted input word
        logic store_write;  // write the captured sample into the store
        logic scan_start;   // clear the window counters, latch the window origin
        logic scan_step;    // read one window position and advance
        logic out_load;     // move the finished result into the output register
    } mp2d_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_query;
        logic item_ok;
        logic kernel_empty;
        logic scan_last;
        logic out_free;
    } mp2d_stat_t;

endpackage
`default_nettype wire

/* rtl/core/mp2d_ram.sv */
// Generic single-port RAM with registered read data.
`default_nettype none
module mp2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One access per cycle: write, and read the same address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* rtl/core/mp2d_ctrl.sv */
// Controller state machine that sequences writes, window scans and result hand-off.
`default_nettype none
module mp2d_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire mp2d_pkg::mp2d_stat_t stat,
    output mp2d_pkg::mp2d_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_FLUSH,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!stat.is_query)
                begin
                    cmd.store_write = stat.item_ok;
                    state_next      = ST_FINISH;
                end
                else if (!stat.item_ok || stat.kernel_empty)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                // The last read returns and is compared in this cycle.
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/mp2d_dp.sv */
// Datapath: configuration registers, range checks, window scan, max compare and output word.
`default_nettype none
module mp2d_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [mp2d_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [mp2d_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                func,
    input  wire logic [mp2d_pkg::ROW_W-1:0]          row,
    input  wire logic [mp2d_pkg::COL_W-1:0]          col,
    input  wire logic [mp2d_pkg::CHAN_W-1:0]         chan,
    input  wire logic signed [mp2d_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                                out_stall,
    output logic                                     out_valid,
    output logic signed [mp2d_pkg::SAMPLE_W-1:0]     max_value,
    output logic [mp2d_pkg::INDEX_W-1:0]             max_index,
    output logic                                     status,
    input  wire mp2d_pkg::mp2d_cmd_t                 cmd,
    output mp2d_pkg::mp2d_stat_t                     stat
);

    // Configuration registers.
    logic [2:0] kernel_reg;
    logic [1:0] pad_reg;
    logic [2:0] step_reg;
    logic [5:0] height_reg;
    logic [5:0] width_reg;
    logic [3:0] chans_reg;

    // Captured input word.
    logic                                  func_reg;
    logic [mp2d_pkg::ROW_W-1:0]            row_reg;
    logic [mp2d_pkg::COL_W-1:0]            col_reg;
    logic [mp2d_pkg::CHAN_W-1:0]           chan_reg;
    logic signed [mp2d_pkg::SAMPLE_W-1:0]  sample_reg;

    // Effective settings after saturation.
    logic [2:0] k_eff;
    logic [2:0] s_eff;
    logic [5:0] h_eff;
    logic [5:0] w_eff;
    logic [3:0] nc_eff;

    // Range checks.
    logic [7:0] row_scaled;
    logic [7:0] col_scaled;
    logic [6:0] ext_h;
    logic [6:0] ext_w;
    logic       write_ok;
    logic       query_ok;
    logic       item_ok;

    // Window scan.
    logic signed [9:0] base_y_reg;
    logic signed [9:0] base_x_reg;
    logic signed [9:0] base_y_next;
    logic signed [9:0] base_x_next;
    logic [2:0]        m_reg;
    logic [2:0]        n_reg;
    logic [mp2d_pkg::INDEX_W-1:0] pos_reg;
    logic signed [9:0] pos_y;
    logic signed [9:0] pos_x;
    logic              pos_inside;
    logic              row_end;
    logic [mp2d_pkg::ADDR_W-1:0] scan_addr;
    logic [mp2d_pkg::ADDR_W-1:0] write_addr;
    logic [mp2d_pkg::ADDR_W-1:0] ram_addr;
    logic [mp2d_pkg::SAMPLE_W-1:0] ram_rdata;

    // Compare stage.
    logic                                  pend_valid_reg;
    logic                                  pend_inside_reg;
    logic [mp2d_pkg::INDEX_W-1:0]          pend_pos_reg;
    logic signed [mp2d_pkg::SAMPLE_W-1:0]  cand;
    logic signed [mp2d_pkg::SAMPLE_W-1:0]  best_reg;
    logic [mp2d_pkg::INDEX_W-1:0]          best_idx_reg;

    // Output register.
    logic                                  out_valid_reg;
    logic signed [mp2d_pkg::SAMPLE_W-1:0]  max_value_reg;
    logic [mp2d_pkg::INDEX_W-1:0]          max_index_reg;
    logic                                  status_reg;

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg <= 3'd2;
            pad_reg    <= 2'd0;
            step_reg   <= 3'd2;
            height_reg <= 6'd32;
            width_reg  <= 6'd32;
            chans_reg  <= 4'd8;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mp2d_pkg::CFG_KERNEL:   kernel_reg <= cfg_data[2:0];
                mp2d_pkg::CFG_PAD:      pad_reg    <= cfg_data[1:0];
                mp2d_pkg::CFG_STEP:     step_reg   <= cfg_data[2:0];
                mp2d_pkg::CFG_HEIGHT:   height_reg <= cfg_data[5:0];
                mp2d_pkg::CFG_WIDTH:    width_reg  <= cfg_data[5:0];
                mp2d_pkg::CFG_CHANNELS: chans_reg  <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // Saturate oversized settings; a zero stride acts as one.
    assign k_eff  = (kernel_reg > 3'(mp2d_pkg::MAX_KERNEL)) ? 3'(mp2d_pkg::MAX_KERNEL)
                                                             : kernel_reg;
    assign s_eff  = (step_reg == 3'd0) ? 3'd1 : step_reg;
    assign h_eff  = (height_reg > 6'(mp2d_pkg::MAX_HEIGHT)) ? 6'(mp2d_pkg::MAX_HEIGHT)
                                                             : height_reg;
    assign w_eff  = (width_reg > 6'(mp2d_pkg::MAX_WIDTH)) ? 6'(mp2d_pkg::MAX_WIDTH)
                                                           : width_reg;
    assign nc_eff = (chans_reg > 4'(mp2d_pkg::MAX_CHANNELS)) ? 4'(mp2d_pkg::MAX_CHANNELS)
                                                              : chans_reg;

    // Capture the accepted input word.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= func;
            row_reg    <= row;
            col_reg    <= col;
            chan_reg   <= chan;
            sample_reg <= sample;
        end
    end

    // An output position is on the grid when pos*stride + kernel fits in the padded extent.
    assign row_scaled = 8'({3'b000, row_reg} * {5'b00000, s_eff});
    assign col_scaled = 8'({3'b000, col_reg} * {5'b00000, s_eff});
    assign ext_h      = {1'b0, h_eff} + {4'b0000, pad_reg, 1'b0};
    assign ext_w      = {1'b0, w_eff} + {4'b0000, pad_reg, 1'b0};

    assign write_ok = ({1'b0, row_reg} < h_eff) && ({1'b0, col_reg} < w_eff)
                   && ({1'b0, chan_reg} < nc_eff);
    assign query_ok = (ext_h >= {4'b0000, k_eff}) && (ext_w >= {4'b0000, k_eff})
                   && (({1'b0, row_scaled} + {6'b0, k_eff}) <= {2'b00, ext_h})
                   && (({1'b0, col_scaled} + {6'b0, k_eff}) <= {2'b00, ext_w})
                   && ({1'b0, chan_reg} < nc_eff);
    assign item_ok  = (func_reg == mp2d_pkg::FUNC_QUERY) ? query_ok : write_ok;

    // Window origin in image coordinates, may be negative.
    assign base_y_next = $signed({2'b00, row_scaled}) - $signed({8'b0, pad_reg});
    assign base_x_next = $signed({2'b00, col_scaled}) - $signed({8'b0, pad_reg});

    assign pos_y      = base_y_reg + $signed({7'b0, m_reg});
    assign pos_x      = base_x_reg + $signed({7'b0, n_reg});
    assign pos_inside = !pos_y[9] && !pos_x[9]
                     && (pos_y < $signed({4'b0000, h_eff}))
                     && (pos_x < $signed({4'b0000, w_eff}));
    assign row_end    = (n_reg == k_eff - 3'd1);

    // Window counters walk the kernel in row-major order.
    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            base_y_reg <= base_y_next;
            base_x_reg <= base_x_next;
            m_reg      <= 3'd0;
            n_reg      <= 3'd0;
            pos_reg    <= '0;
        end
        else if (cmd.scan_step)
        begin
            if (row_end)
            begin
                n_reg <= 3'd0;
                m_reg <= m_reg + 3'd1;
            end
            else
            begin
                n_reg <= n_reg + 3'd1;
            end
            pos_reg <= pos_reg + mp2d_pkg::INDEX_W'(1);
        end
    end

    // Store addresses: (row * width + column) * channels + channel.
    assign scan_addr  = mp2d_pkg::ADDR_W'(
        (mp2d_pkg::ADDR_W'(pos_y[mp2d_pkg::ROW_W-1:0]) * mp2d_pkg::ADDR_W'(mp2d_pkg::MAX_WIDTH)
         + mp2d_pkg::ADDR_W'(pos_x[mp2d_pkg::COL_W-1:0]))
        * mp2d_pkg::ADDR_W'(mp2d_pkg::MAX_CHANNELS) + mp2d_pkg::ADDR_W'(chan_reg));
    assign write_addr = mp2d_pkg::ADDR_W'(
        (mp2d_pkg::ADDR_W'(row_reg) * mp2d_pkg::ADDR_W'(mp2d_pkg::MAX_WIDTH)
         + mp2d_pkg::ADDR_W'(col_reg))
        * mp2d_pkg::ADDR_W'(mp2d_pkg::MAX_CHANNELS) + mp2d_pkg::ADDR_W'(chan_reg));
    assign ram_addr   = cmd.store_write ? write_addr : scan_addr;

    mp2d_ram #(
        .WIDTH(mp2d_pkg::SAMPLE_W),
        .DEPTH(mp2d_pkg::STORE_DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (cmd.store_write),
        .addr (ram_addr),
        .wdata(sample_reg),
        .rdata(ram_rdata)
    );

    // Track the position whose read is in flight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= cmd.scan_step;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_inside_reg <= pos_inside;
        pend_pos_reg    <= pos_reg;
    end

    // Padding reads as zero; keep the first strictly greater value.
    assign cand = pend_inside_reg ? $signed(ram_rdata) : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            best_reg     <= mp2d_pkg::SAMPLE_MIN;
            best_idx_reg <= '0;
        end
        else if (pend_valid_reg && (cand > best_reg))
        begin
            best_reg     <= cand;
            best_idx_reg <= pend_pos_reg;
        end
    end

    // Output register: holds one finished word until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg <= !item_ok;
            if ((func_reg == mp2d_pkg::FUNC_QUERY) && item_ok)
            begin
                max_value_reg <= best_reg;
                max_index_reg <= best_idx_reg;
            end
            else
            begin
                max_value_reg <= '0;
                max_index_reg <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign max_value = max_value_reg;
    assign max_index = max_index_reg;
    assign status    = status_reg;

    // Status toward the controller.
    always_comb
    begin
        stat              = '0;
        stat.is_query     = (func_reg == mp2d_pkg::FUNC_QUERY);
        stat.item_ok      = item_ok;
        stat.kernel_empty = (k_eff == 3'd0);
        stat.scan_last    = row_end && (m_reg == k_eff - 3'd1);
        stat.out_free     = !out_valid_reg || !out_stall;
    end

endmodule
`default_nettype wire

/* rtl/core/max_pool_2d_with_argmax.sv */
// Top level of the 2-D max pooling block with argmax over a stored image.
`default_nettype none
// Software loads an image of up to 32 rows, 32 columns and 8 channels of 16-bit signed
// samples with write words (func 0), then sends query words (func 1) that each return the
// maximum of a kernel_size by kernel_size window at (row*step - pad, col*step - pad) and
// the row-major window index of its first occurrence; padding positions count as zero.
// Every input word yields exactly one result word, with status 1 for coordinates outside
// the image or the pooled grid. One word is handled at a time. A write, and a query that
// is out of range or has an empty kernel, passes ST_CHECK and then waits in ST_FINISH
// until the result register is free; an in-range query passes ST_CHECK, then ST_SCAN, which
// walks the window in row-major order, then ST_FLUSH and ST_FINISH; the single port of the
// sample store gives one window read per cycle. The next word is accepted the cycle after
// the result is loaded, even while that result still waits to be taken; a result that
// finds the previous one still stalled waits until it is taken. The store has no reset;
// every sample must be written before a query reads it. The user must write the
// configuration registers only while no word is in flight; the block itself does not
// enforce this.
module max_pool_2d_with_argmax (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [mp2d_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [mp2d_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic                                  func,
    input  wire logic [mp2d_pkg::ROW_W-1:0]            row,
    input  wire logic [mp2d_pkg::COL_W-1:0]            col,
    input  wire logic [mp2d_pkg::CHAN_W-1:0]           chan,
    input  wire logic signed [mp2d_pkg::SAMPLE_W-1:0]  sample,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [mp2d_pkg::SAMPLE_W-1:0]       max_value,
    output logic [mp2d_pkg::INDEX_W-1:0]               max_index,
    output logic                                       status
);

    mp2d_pkg::mp2d_cmd_t  cmd;
    mp2d_pkg::mp2d_stat_t stat;

    // Sequencer.
    mp2d_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Store, compare logic and output register.
    mp2d_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .func     (func),
        .row      (row),
        .col      (col),
        .chan     (chan),
        .sample   (sample),
        .out_stall(out_stall),
        .out_valid(out_valid),
        .max_value(max_value),
        .max_index(max_index),
        .status   (status),
        .cmd      (cmd),
        .stat     (stat)
    );

`ifndef SYNTHESIS
    // Only one word is in flight: an accepted word closes the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while a word is in flight");

    // A flagged result carries zero value and zero index.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (max_value == '0 && max_index == '0))
        else $error("flagged result with nonzero payload");

    // The window index never passes the last kernel position.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (max_index <= mp2d_pkg::INDEX_W'(
            mp2d_pkg::MAX_KERNEL * mp2d_pkg::MAX_KERNEL - 1)))
        else $error("window index out of range");

    // A result is only loaded while the output register is free or draining.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("result overwritten before it was taken");
`endif

endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for the max pooling block with argmax over a stored image.
`timescale 1ns / 1ps
module tb_top;
    import mp2d_pkg::*;

    // One result word as the bench expects it.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic [INDEX_W-1:0]         index;
        logic                       stat;
    } pool_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       func = FUNC_WRITE;
    logic [ROW_W-1:0]           row = '0;
    logic [COL_W-1:0]           col = '0;
    logic [CHAN_W-1:0]          chan = '0;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] max_value;
    logic [INDEX_W-1:0]         max_index;
    logic                       status;

    // Shadow copy of the configuration, starting from the reset values.
    logic [2:0] kernel_reg = 3'd2;
    logic [1:0] pad_reg    = 2'd0;
    logic [2:0] step_reg   = 3'd2;
    logic [5:0] height_reg = 6'd32;
    logic [5:0] width_reg  = 6'd32;
    logic [3:0] chans_reg  = 4'd8;

    // Shadow copy of the image store and a record of which entries hold data.
    logic signed [SAMPLE_W-1:0] pixel_mem [STORE_DEPTH];
    bit                         sample_written [STORE_DEPTH];

    pool_result_t pool_results_due [$];
    int errors = 0;
    int words_sent = 0;
    int sample_style = 0;
    int stall_left = 0;
    bit in_gaps = 1'b0;
    bit out_gaps = 1'b0;

    max_pool_2d_with_argmax i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .row       (row),
        .col       (col),
        .chan      (chan),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .max_value (max_value),
        .max_index (max_index),
        .status    (status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Effective settings after saturation and the zero-stride rule.
    function automatic int eff_height();
        return (int'(height_reg) > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    endfunction

    function automatic int eff_width();
        return (int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    endfunction

    function automatic int eff_chans();
        return (int'(chans_reg) > MAX_CHANNELS) ? MAX_CHANNELS : int'(chans_reg);
    endfunction

    function automatic int eff_step();
        return (step_reg == 3'd0) ? 1 : int'(step_reg);
    endfunction

    // Number of pooled outputs along one axis of the given extent.
    function automatic int pooled_count(input int extent);
        int span;
        span = extent + 2 * int'(pad_reg);
        return (span >= int'(kernel_reg)) ? (span - int'(kernel_reg)) / eff_step() + 1 : 0;
    endfunction

    function automatic bit query_in_grid(input int r, input int c, input int ch);
        return r < pooled_count(eff_height()) && c < pooled_count(eff_width()) &&
               ch < eff_chans();
    endfunction

    function automatic int store_addr(input int y, input int x, input int ch);
        return (y * MAX_WIDTH + x) * MAX_CHANNELS + ch;
    endfunction

    function automatic bit in_image(input int y, input int x);
        return y >= 0 && x >= 0 && y < eff_height() && x < eff_width();
    endfunction

    // Applies one accepted word to the shadow store and returns the result it must give.
    function automatic pool_result_t predict_pool(input logic f, input int r, input int c,
                                                  input int ch,
                                                  input logic signed [SAMPLE_W-1:0] smp);
        pool_result_t res;
        int best;
        int best_idx;
        int y;
        int x;
        int val;
        res = '0;
        if (f == FUNC_WRITE)
        begin
            if (r >= eff_height() || c >= eff_width() || ch >= eff_chans())
            begin
                res.stat = 1'b1;
            end
            else
            begin
                pixel_mem[store_addr(r, c, ch)] = smp;
                sample_written[store_addr(r, c, ch)] = 1'b1;
            end
        end
        else if (!query_in_grid(r, c, ch))
        begin
            res.stat = 1'b1;
        end
        else
        begin
            // Row-major scan; padding reads as zero and only a strictly larger value wins.
            best = -(2 ** (SAMPLE_W - 1));
            best_idx = 0;
            for (int m = 0; m < int'(kernel_reg); m++)
            begin
                for (int n = 0; n < int'(kernel_reg); n++)
                begin
                    y = r * eff_step() + m - int'(pad_reg);
                    x = c * eff_step() + n - int'(pad_reg);
                    val = 0;
                    if (in_image(y, x))
                        val = int'(pixel_mem[store_addr(y, x, ch)]);
                    if (val > best)
                    begin
                        best = val;
                        best_idx = m * int'(kernel_reg) + n;
                    end
                end
            end
            res.value = best[SAMPLE_W-1:0];
            res.index = best_idx[INDEX_W-1:0];
        end
        return res;
    endfunction

    // Sample values: full range, tightly clustered for ties, extremes, or negative only.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int style);
        case (style)
            0: return SAMPLE_W'($urandom());
            1: return SAMPLE_W'(int'($urandom_range(0, 6)) - 3);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return 16'sh8000;
                    1: return 16'sh7fff;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return SAMPLE_W'(-int'($urandom_range(1, 32768)));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    // Sends one input word, waits for it to be taken and records the result it owes.
    task automatic send_word(input logic f, input int r, input int c, input int ch,
                             input logic signed [SAMPLE_W-1:0] smp);
        @(negedge clk);
        if (in_gaps && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        row      <= r[ROW_W-1:0];
        col      <= c[COL_W-1:0];
        chan     <= ch[CHAN_W-1:0];
        sample   <= smp;
        do @(posedge clk); while (in_stall);
        pool_results_due.push_back(predict_pool(f, r, c, ch, smp));
        words_sent++;
    endtask

    // Drops valid and waits until every owed result has been taken.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pool_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes all six registers, one per cycle, once the block is idle.
    task automatic set_config(input int k, input int p, input int s, input int h,
                              input int w, input int nc);
        logic [CFG_DATA_W-1:0]  vals [6];
        logic [CFG_INDEX_W-1:0] regs [6];
        vals = '{CFG_DATA_W'(k), CFG_DATA_W'(p), CFG_DATA_W'(s), CFG_DATA_W'(h),
                 CFG_DATA_W'(w), CFG_DATA_W'(nc)};
        regs = '{CFG_KERNEL, CFG_PAD, CFG_STEP, CFG_HEIGHT, CFG_WIDTH, CFG_CHANNELS};
        wait_idle();
        for (int i = 0; i < 6; i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        kernel_reg = k[2:0];
        pad_reg    = p[1:0];
        step_reg   = s[2:0];
        height_reg = h[5:0];
        width_reg  = w[5:0];
        chans_reg  = nc[3:0];
    endtask

    // Writes the image samples a query window needs: all missing ones, and with
    // refresh set a random share of those already present.
    task automatic write_window(input int r, input int c, input int ch, input bit refresh);
        int y;
        int x;
        for (int m = 0; m < int'(kernel_reg); m++)
        begin
            for (int n = 0; n < int'(kernel_reg); n++)
            begin
                y = r * eff_step() + m - int'(pad_reg);
                x = c * eff_step() + n - int'(pad_reg);
                if (in_image(y, x) &&
                    (!sample_written[store_addr(y, x, ch)] ||
                     (refresh && $urandom_range(0, 1) == 1)))
                    send_word(FUNC_WRITE, y, x, ch, pick_sample(sample_style));
            end
        end
    endtask

    // A query, preceded by the writes that keep it from reading unwritten samples.
    task automatic pool_query(input int r, input int c, input int ch, input bit refresh);
        if (query_in_grid(r, c, ch))
            write_window(r, c, ch, refresh);
        send_word(FUNC_QUERY, r, c, ch, SAMPLE_W'($urandom()));
    endtask

    // Field extremes and a constant window under the reset settings.
    task automatic test_reset_settings();
        send_word(FUNC_WRITE, 31, 31, 7, 16'sh7fff);
        for (int i = 0; i < 4; i++)
            send_word(FUNC_WRITE, i / 2, i % 2, 0, 16'sh8000);
        pool_query(0, 0, 0, 1'b0);
        sample_style = 1;
        pool_query(15, 15, 7, 1'b1);
        pool_query(16, 0, 0, 1'b0);
        pool_query(0, 16, 0, 1'b0);
    endtask

    // Small padded image: range checks on writes and queries, padding against
    // negative samples, and the first of equal maxima.
    task automatic test_padding_and_ranges();
        set_config(3, 1, 1, 3, 3, 1);
        send_word(FUNC_WRITE, 3, 0, 0, 16'sh1234);
        send_word(FUNC_WRITE, 0, 3, 0, 16'sh1234);
        send_word(FUNC_WRITE, 0, 0, 1, 16'sh1234);
        for (int i = 0; i < 9; i++)
            send_word(FUNC_WRITE, i / 3, i % 3, 0, pick_sample(3));
        pool_query(0, 0, 0, 1'b0);
        pool_query(1, 1, 0, 1'b0);
        send_word(FUNC_WRITE, 2, 2, 0, 16'sd5);
        send_word(FUNC_WRITE, 1, 2, 0, 16'sd5);
        pool_query(1, 1, 0, 1'b0);
        pool_query(3, 0, 0, 1'b0);
        pool_query(0, 3, 0, 1'b0);
    endtask

    // Empty kernel, zero stride, oversized extents and empty image or channel set.
    task automatic test_degenerate_settings();
        set_config(0, 2, 0, 3, 3, 1);
        pool_query(0, 0, 0, 1'b0);
        pool_query(7, 7, 0, 1'b0);
        pool_query(8, 0, 0, 1'b0);
        set_config(7, 3, 7, 63, 40, 15);
        sample_style = 0;
        send_word(FUNC_WRITE, 31, 31, 7, 16'sh8000);
        pool_query(4, 4, 7, 1'b0);
        pool_query(5, 0, 0, 1'b0);
        set_config(2, 0, 1, 0, 5, 0);
        send_word(FUNC_WRITE, 0, 0, 0, 16'sh0001);
        pool_query(0, 0, 0, 1'b0);
    endtask

    // Random extent: mostly small, now and then empty, or at or beyond the maximum.
    function automatic int pick_extent();
        case ($urandom_range(0, 19))
            0: return 0;
            1, 2: return $urandom_range(32, 63);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    // Random settings per phase; most words are filled windows followed by their query.
    task automatic run_pool_phases(input int word_goal, input bit idling);
        int nc;
        int phase_end;
        int action;
        int rows;
        int cols;
        while (words_sent < word_goal)
        begin
            case ($urandom_range(0, 19))
                0: nc = 0;
                1: nc = $urandom_range(8, 15);
                default: nc = $urandom_range(1, 4);
            endcase
            set_config(($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 7),
                       $urandom_range(0, 3), $urandom_range(0, 7),
                       pick_extent(), pick_extent(), nc);
            in_gaps  = idling && $urandom_range(0, 3) != 0;
            out_gaps = idling && $urandom_range(0, 3) != 0;
            phase_end = words_sent + $urandom_range(40, 120);
            while (words_sent < phase_end && words_sent < word_goal)
            begin
                sample_style = $urandom_range(0, 3);
                rows = (pooled_count(eff_height()) > 32) ? 32 : pooled_count(eff_height());
                cols = (pooled_count(eff_width()) > 32) ? 32 : pooled_count(eff_width());
                action = $urandom_range(0, 19);
                if (action < 14 && rows > 0 && cols > 0 && eff_chans() > 0)
                    pool_query($urandom_range(0, rows - 1), $urandom_range(0, cols - 1),
                               $urandom_range(0, eff_chans() - 1),
                               1'($urandom_range(0, 1)));
                else if (action < 17)
                    send_word(FUNC_WRITE, $urandom_range(0, 31), $urandom_range(0, 31),
                              $urandom_range(0, 7), pick_sample(sample_style));
                else
                    pool_query($urandom_range(0, 31), $urandom_range(0, 31),
                               $urandom_range(0, 7), 1'b0);
            end
        end
    endtask

    task automatic test_random_phases();
        run_pool_phases(1150, 1'b1);
    endtask

    task automatic test_full_rate();
        run_pool_phases(1250, 1'b0);
    endtask

    // Result stall in random bursts.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (out_gaps && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 6);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Each accepted result word against the oldest expectation.
    always @(posedge clk)
    begin : check_results
        pool_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pool_results_due.size() == 0)
            begin
                report_mismatch("unexpected result word", int'(status), 0);
            end
            else
            begin
                want = pool_results_due.pop_front();
                if (max_value !== want.value)
                    report_mismatch("max_value", int'(max_value), int'(want.value));
                if (max_index !== want.index)
                    report_mismatch("max_index", int'(max_index), int'(want.index));
                if (status !== want.stat)
                    report_mismatch("status", int'(status), int'(want.stat));
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_settings();
        test_padding_and_ranges();
        test_degenerate_settings();
        test_random_phases();
        test_full_rate();
        wait_idle();
        repeat (60) @(posedge clk);
        if (errors == 0 && pool_results_due.size() == 0)
            $display("PASS max_pool_2d_with_argmax");
        else
            $display("FAIL max_pool_2d_with_argmax");
        $finish;
    end

    // Guard against a hang.
    initial
    begin
        #2000000;
        $display("FAIL max_pool_2d_with_argmax");
        $finish;
    end

endmodule

/* files.f */
rtl/core/mp2d_pkg.sv
rtl/core/mp2d_ram.sv
rtl/core/mp2d_ctrl.sv
rtl/core/mp2d_dp.sv
rtl/core/max_pool_2d_with_argmax.sv
bench/tb_top.sv
